FILE: hw/rtl/bdq_pkg.sv
// shared types, constants and helpers for the bounded deque with search
package bdq_pkg;

	localparam int CAPACITY  = 16;
	localparam int IDX_W     = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int VAL_W     = 32;
	localparam int KIND_W    = 3;
	localparam int STATUS_W  = 2;

	typedef enum logic [KIND_W-1:0] {
		K_PUSH_FRONT   = 3'd0,
		K_PUSH_BACK    = 3'd1,
		K_POP_FRONT    = 3'd2,
		K_POP_BACK     = 3'd3,
		K_REMOVE_FIRST = 3'd4,
		K_EXISTS       = 3'd5,
		K_CLEAR        = 3'd6
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// commands from controller to datapath
	typedef struct packed {
		logic    op_load;
		logic    push_front;
		logic    push_back;
		logic    pop_front;
		logic    pop_back;
		logic    clear;
		logic    stream;
		logic    shift_wr;
		logic    seek;
		logic    remove_dec;
		logic    rd_front;
		logic    rd_back;
		logic    cap_front;
		logic    out_load;
		status_t status;
		logic    found;
	} bdq_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              full;
		logic              empty;
		logic              match;
		logic              stream_idle;
	} bdq_stat_t;

	// circular slot of logical offset off from base
	function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] base,
			input logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
		if (sum >= (CNT_W+1)'(CAPACITY)) begin
			sum = sum - (CNT_W+1)'(CAPACITY);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

FILE: hw/rtl/bdq_ram.sv
// generic single-write, single-read ram with registered read data
module bdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/bdq_dpath.sv
// deque datapath: indices, count, entry ram, search compare and result register
module bdq_dpath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  bdq_pkg::bdq_cmd_t                     cmd,
	output bdq_pkg::bdq_stat_t                    stat,
	input  logic [bdq_pkg::KIND_W-1:0]            in_kind,
	input  logic [bdq_pkg::VAL_W-1:0]             in_value,
	output logic [bdq_pkg::STATUS_W-1:0]          out_status,
	output logic                                  out_found,
	output logic [bdq_pkg::CNT_W-1:0]             out_count,
	output logic [bdq_pkg::VAL_W-1:0]             out_front,
	output logic [bdq_pkg::VAL_W-1:0]             out_back
);

	logic [bdq_pkg::KIND_W-1:0]  kind_q;
	logic [bdq_pkg::VAL_W-1:0]   value_q;
	logic [bdq_pkg::IDX_W-1:0]   fi_q;
	logic [bdq_pkg::CNT_W-1:0]   cnt_q;
	logic [bdq_pkg::CNT_W-1:0]   pos_q;
	logic [bdq_pkg::CNT_W-1:0]   rpos_q;
	logic                        rvalid_q;
	logic [bdq_pkg::VAL_W-1:0]   front_q;

	logic                        we;
	logic [bdq_pkg::IDX_W-1:0]   waddr;
	logic                        re;
	logic [bdq_pkg::IDX_W-1:0]   raddr;
	logic [bdq_pkg::VAL_W-1:0]   rdata;
	logic [bdq_pkg::VAL_W-1:0]   wdata;
	logic [bdq_pkg::IDX_W-1:0]   fi_dec;
	logic [bdq_pkg::IDX_W-1:0]   fi_inc;
	logic                        can_issue;

	assign fi_dec    = (fi_q == '0) ? bdq_pkg::IDX_W'(bdq_pkg::CAPACITY - 1) :
	                   fi_q - bdq_pkg::IDX_W'(1);
	assign fi_inc    = bdq_pkg::slot_add(fi_q, bdq_pkg::CNT_W'(1));
	assign can_issue = cmd.stream && (pos_q < cnt_q);

	// write port select
	always_comb begin
		we    = 1'b0;
		waddr = fi_q;
		wdata = value_q;
		if (cmd.push_front) begin
			we    = 1'b1;
			waddr = fi_dec;
		end else if (cmd.push_back) begin
			we    = 1'b1;
			waddr = bdq_pkg::slot_add(fi_q, cnt_q);
		end else if (cmd.shift_wr && rvalid_q) begin
			we    = 1'b1;
			waddr = bdq_pkg::slot_add(fi_q, rpos_q - bdq_pkg::CNT_W'(1));
			wdata = rdata;
		end
	end

	// read port select
	always_comb begin
		re    = 1'b0;
		raddr = fi_q;
		if (can_issue) begin
			re    = 1'b1;
			raddr = bdq_pkg::slot_add(fi_q, pos_q);
		end else if (cmd.rd_front) begin
			re    = 1'b1;
			raddr = fi_q;
		end else if (cmd.rd_back) begin
			re    = 1'b1;
			raddr = bdq_pkg::slot_add(fi_q, cnt_q - bdq_pkg::CNT_W'(1));
		end
	end

	bdq_ram #(
		.WIDTH (bdq_pkg::VAL_W),
		.DEPTH (bdq_pkg::CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// status to controller
	assign stat.kind        = kind_q;
	assign stat.full        = (cnt_q == bdq_pkg::CNT_W'(bdq_pkg::CAPACITY));
	assign stat.empty       = (cnt_q == '0);
	assign stat.match       = rvalid_q && (rdata == value_q);
	assign stat.stream_idle = !rvalid_q && (pos_q >= cnt_q);

	// control registers: indices, count, scan position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= '0;
			fi_q     <= '0;
			cnt_q    <= '0;
			pos_q    <= '0;
			rpos_q   <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (cmd.op_load) begin
				kind_q   <= in_kind;
				pos_q    <= '0;
				rvalid_q <= 1'b0;
			end else if (cmd.seek) begin
				pos_q    <= rpos_q + bdq_pkg::CNT_W'(1);
				rvalid_q <= 1'b0;
			end else if (cmd.stream) begin
				rvalid_q <= can_issue;
				if (can_issue) begin
					rpos_q <= pos_q;
					pos_q  <= pos_q + bdq_pkg::CNT_W'(1);
				end
			end
			if (cmd.clear) begin
				fi_q  <= '0;
				cnt_q <= '0;
			end else if (cmd.push_front) begin
				fi_q  <= fi_dec;
				cnt_q <= cnt_q + bdq_pkg::CNT_W'(1);
			end else if (cmd.push_back) begin
				cnt_q <= cnt_q + bdq_pkg::CNT_W'(1);
			end else if (cmd.pop_front) begin
				fi_q  <= fi_inc;
				cnt_q <= cnt_q - bdq_pkg::CNT_W'(1);
			end else if (cmd.pop_back || cmd.remove_dec) begin
				cnt_q <= cnt_q - bdq_pkg::CNT_W'(1);
			end
		end
	end

	// payload registers: operand, front capture, result
	always_ff @(posedge clk) begin
		if (cmd.op_load) begin
			value_q <= in_value;
		end
		if (cmd.cap_front) begin
			front_q <= rdata;
		end
		if (cmd.out_load) begin
			out_status <= cmd.status;
			out_found  <= cmd.found;
			out_count  <= cnt_q;
			out_front  <= (cnt_q == '0) ? '0 : front_q;
			out_back   <= (cnt_q == '0) ? '0 : rdata;
		end
	end

endmodule

FILE: hw/rtl/bdq_ctrl.sv
// deque controller: operation sequencing and result handshake
module bdq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  bdq_pkg::bdq_stat_t stat,
	output bdq_pkg::bdq_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_SHIFT,
		S_REF_FRONT,
		S_REF_BACK,
		S_FINISH
	} state_t;

	state_t           state_q;
	bdq_pkg::status_t status_q;
	logic             found_q;
	logic             out_free;

	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid || out_ready;

	// command decode per state
	always_comb begin
		cmd        = '0;
		cmd.status = status_q;
		cmd.found  = found_q;
		case (state_q)
			S_IDLE: begin
				cmd.op_load = in_valid;
			end
			S_DECODE: begin
				case (bdq_pkg::kind_t'(stat.kind))
					bdq_pkg::K_PUSH_FRONT: cmd.push_front = !stat.full;
					bdq_pkg::K_PUSH_BACK:  cmd.push_back  = !stat.full;
					bdq_pkg::K_POP_FRONT:  cmd.pop_front  = !stat.empty;
					bdq_pkg::K_POP_BACK:   cmd.pop_back   = !stat.empty;
					bdq_pkg::K_CLEAR:      cmd.clear      = 1'b1;
					default: ;
				endcase
			end
			S_SCAN: begin
				if (stat.match &&
						bdq_pkg::kind_t'(stat.kind) == bdq_pkg::K_REMOVE_FIRST) begin
					cmd.seek = 1'b1;
				end else begin
					cmd.stream = 1'b1;
				end
			end
			S_SHIFT: begin
				cmd.stream     = 1'b1;
				cmd.shift_wr   = 1'b1;
				cmd.remove_dec = stat.stream_idle;
			end
			S_REF_FRONT: begin
				cmd.rd_front = 1'b1;
			end
			S_REF_BACK: begin
				cmd.rd_back   = 1'b1;
				cmd.cap_front = 1'b1;
			end
			S_FINISH: begin
				cmd.out_load = out_free;
			end
			default: ;
		endcase
	end

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			status_q  <= bdq_pkg::ST_OK;
			found_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			// result valid: set when the result register loads, dropped on its transaction
			if (state_q == S_FINISH && out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					found_q <= 1'b0;
					case (bdq_pkg::kind_t'(stat.kind))
						bdq_pkg::K_PUSH_FRONT, bdq_pkg::K_PUSH_BACK: begin
							status_q <= stat.full ? bdq_pkg::ST_FULL : bdq_pkg::ST_OK;
							state_q  <= S_REF_FRONT;
						end
						bdq_pkg::K_POP_FRONT, bdq_pkg::K_POP_BACK: begin
							status_q <= stat.empty ? bdq_pkg::ST_EMPTY : bdq_pkg::ST_OK;
							state_q  <= S_REF_FRONT;
						end
						bdq_pkg::K_REMOVE_FIRST, bdq_pkg::K_EXISTS: begin
							status_q <= bdq_pkg::ST_OK;
							state_q  <= S_SCAN;
						end
						default: begin
							status_q <= bdq_pkg::ST_OK;
							state_q  <= S_REF_FRONT;
						end
					endcase
				end
				S_SCAN: begin
					if (stat.match) begin
						found_q <= 1'b1;
						if (bdq_pkg::kind_t'(stat.kind) == bdq_pkg::K_REMOVE_FIRST) begin
							state_q <= S_SHIFT;
						end else begin
							state_q <= S_REF_FRONT;
						end
					end else if (stat.stream_idle) begin
						status_q <= bdq_pkg::ST_NOT_FOUND;
						state_q  <= S_REF_FRONT;
					end
				end
				S_SHIFT: begin
					if (stat.stream_idle) begin
						state_q <= S_REF_FRONT;
					end
				end
				S_REF_FRONT: begin
					state_q <= S_REF_BACK;
				end
				S_REF_BACK: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/bounded_deque_with_search.sv
// Bounded deque with search: push/pop at both ends, remove-first, exists, clear.
// Sequence: decode; for exists and remove-first a scan that stops at the first match or at
// the end; for remove-first a shift of the entries behind the match toward the front; then
// reads of the front and back entries and a load of the result register.
// Throughput: one transaction in flight; s_tready rises in the same cycle as m_tvalid,
// and a result not yet taken holds the following one back in its last state.
// Reset: arst_n clears count, front index and handshake state; entries are not cleared.
module bounded_deque_with_search (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [2:0]  s_tuser,   // [2:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // [1:0] status, [2] found, [7:3] count,
	                               // [39:8] front_value, [71:40] back_value
);

	bdq_pkg::bdq_cmd_t             cmd;
	bdq_pkg::bdq_stat_t            stat;
	logic [bdq_pkg::STATUS_W-1:0]  out_status;
	logic                          out_found;
	logic [bdq_pkg::CNT_W-1:0]     out_count;
	logic [bdq_pkg::VAL_W-1:0]     out_front;
	logic [bdq_pkg::VAL_W-1:0]     out_back;

	// sequencing
	bdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// storage and result
	bdq_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_kind    (s_tuser),
		.in_value   (s_tdata),
		.out_status (out_status),
		.out_found  (out_found),
		.out_count  (out_count),
		.out_front  (out_front),
		.out_back   (out_back)
	);

	// result packing
	assign m_tdata = {out_back, out_front, out_count, out_found, out_status};

endmodule

FILE: hw/rtl/bdq_checker.sv
// port-level checks for the bounded deque with search
module bdq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one transaction at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	// count never above capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:3] <= 5'(bdq_pkg::CAPACITY))
		else $error("count above capacity");

	// empty queue shows zero ends
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[7:3] == 5'd0 |-> m_tdata[71:8] == 64'd0)
		else $error("empty queue shows nonzero ends");

	// full status only with a full queue, found only with ok status
	a_status_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |->
			(m_tdata[1:0] != bdq_pkg::ST_FULL || m_tdata[7:3] == 5'(bdq_pkg::CAPACITY)) &&
			(!m_tdata[2] || m_tdata[1:0] == bdq_pkg::ST_OK))
		else $error("status inconsistent with count or found");

endmodule

bind bounded_deque_with_search bdq_checker u_bdq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
